/* rtl/gpa_pkg.sv */
package gpa_pkg;

  // Operand width limit of the arithmetic unit.
  localparam int unsigned MaxWidth = 32;
  localparam int unsigned MainW    = 63;

  // Operation codes carried by a transaction.
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_GCD = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  // Control word that the sequencer hands to every cell in the row.
  typedef struct packed {
    logic load;   // take fresh operands
    logic mul;    // carry-less multiply step
    logic red;    // reduction step (divide or gcd)
    logic swap;   // gcd: exchange remainder and divisor
  } cell_ctl_t;

endpackage

/* rtl/gpa_cell.sv */
// One bit slice of the working row: product/remainder bit r, divisor bit d,
// quotient bit q. Quotient bits move one place toward the high end per reduction step.
module gpa_cell (
  input  logic            clk_i,
  input  gpa_pkg::cell_ctl_t ctl_i,
  input  logic            a_i,       // operand a bit for load
  input  logic            b_i,       // operand b bit for load
  input  logic            mb_i,      // multiplier bit selected this step
  input  logic            lead_i,    // leading remainder bit is set
  input  logic            dsh_i,     // shifted divisor bit for this slice
  input  logic            q_lo_i,    // quotient bit arriving from below
  output logic            r_o,
  output logic            d_o,
  output logic            q_o
);
  import gpa_pkg::*;

  logic r_q, d_q, q_q;
  logic r_d, d_d, q_d;

  // Next value of the slice.
  always_comb begin
    r_d = r_q;
    d_d = d_q;
    q_d = q_q;
    if (ctl_i.load) begin
      r_d = a_i;
      d_d = b_i;
      q_d = 1'b0;
    end else if (ctl_i.mul) begin
      r_d = r_q ^ (mb_i & dsh_i);
    end else if (ctl_i.swap) begin
      r_d = d_q;
      d_d = r_q;
      q_d = 1'b0;
    end else if (ctl_i.red) begin
      r_d = r_q ^ (lead_i & dsh_i);
      q_d = q_lo_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    d_q <= d_d;
    q_q <= q_d;
  end

  assign r_o = r_q;
  assign d_o = d_q;
  assign q_o = q_q;
endmodule

/* rtl/gf2_polynomial_alu_core.sv */
// A multiply steps through the multiplier bits from the low end. A divide or a gcd ends
// without a pass for a zero divisor or the unused opcode; otherwise (once for a divide, and until
// the remainder is zero for a gcd) each pass scans for the divisor degree and then
// reduces the remainder one bit position per cycle across the cell row.
// Throughput: one transaction at a time; the next is accepted at the edge ending done_o.
// Reset (rst_ni low, asynchronous) clears all control and result registers; no stalls.
module gf2_polynomial_alu_core #(
  parameter int unsigned WIDTH = gpa_pkg::MaxWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode_i,
  input  logic [31:0]              operand_a_i,
  input  logic [31:0]              operand_b_i,
  output logic                     done_o,
  output logic [gpa_pkg::MainW-1:0] main_value_o,
  output logic [31:0]              remainder_value_o,
  output logic                     zero_divisor_o
);
  import gpa_pkg::*;

  localparam int unsigned RowW = 2 * WIDTH;
  localparam int unsigned PosW = $clog2(RowW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ALIGN, S_RED, S_NEXT, S_DONE
  } state_e;

  state_e          st_q;
  op_e             op_q;
  logic [WIDTH-1:0] mb_q;      // multiplier bits, shifted out low first
  logic [RowW-1:0] dsh_q;      // shifted divisor / multiplicand
  logic [PosW-1:0] pos_q;      // remainder bit under test
  logic [PosW-1:0] dpos_q;     // divisor degree
  logic            busy_q, done_q, zd_q;
  logic [MainW-1:0] main_q;
  logic [31:0]     rem_q;
  cell_ctl_t       ctl;
  logic [RowW-1:0] r_row, d_row, q_row, a_row, b_row, qlo_row;
  logic            lead;

  // A multiply accumulates from zero; divide and gcd start from operand a.
  assign a_row = (op_e'(opcode_i) == OP_MUL) ? '0 : RowW'(operand_a_i[WIDTH-1:0]);
  assign b_row = RowW'(operand_b_i[WIDTH-1:0]);
  assign lead  = r_row[pos_q[$clog2(RowW)-1:0]];
  // Quotient bits shift up by one and take the new bit at the bottom.
  assign qlo_row = {q_row[RowW-2:0], lead};

  // Row of identical cells.
  for (genvar g = 0; g < RowW; g++) begin : g_cell
    gpa_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .a_i    (a_row[g]),
      .b_i    (b_row[g]),
      .mb_i   (mb_q[0]),
      .lead_i (lead),
      .dsh_i  (dsh_q[g]),
      .q_lo_i (qlo_row[g]),
      .r_o    (r_row[g]),
      .d_o    (d_row[g]),
      .q_o    (q_row[g])
    );
  end

  // Control word for the cells.
  always_comb begin
    ctl      = '0;
    ctl.load = start && !busy_q;
    ctl.mul  = (st_q == S_MUL);
    ctl.red  = (st_q == S_RED) && (pos_q >= dpos_q);
    ctl.swap = (st_q == S_NEXT) && (op_q == OP_GCD) && (r_row != '0);
  end

  // Sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_NOP;
      mb_q   <= '0;
      dsh_q  <= '0;
      pos_q  <= '0;
      dpos_q <= '0;
      zd_q   <= 1'b0;
      main_q <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (start) begin
            busy_q <= 1'b1;
            op_q   <= op_e'(opcode_i);
            mb_q   <= operand_a_i[WIDTH-1:0];
            dsh_q  <= b_row;
            pos_q  <= PosW'(RowW - 1);
            dpos_q <= '0;
            st_q   <= (op_e'(opcode_i) == OP_MUL) ? S_MUL : S_ALIGN;
          end
        end
        S_MUL: begin
          mb_q  <= mb_q >> 1;
          dsh_q <= dsh_q << 1;
          pos_q <= pos_q - PosW'(1);
          if (pos_q == PosW'(RowW - WIDTH)) st_q <= S_DONE;
        end
        // Find the degree of the divisor, one position per cycle.
        S_ALIGN: begin
          if (op_q == OP_NOP || d_row == '0) begin
            st_q <= S_DONE;
          end else if (d_row[pos_q[$clog2(RowW)-1:0]]) begin
            dpos_q <= pos_q;
            pos_q  <= PosW'(RowW - 1);
            dsh_q  <= d_row << (PosW'(RowW - 1) - pos_q);
            st_q   <= S_RED;
          end else begin
            pos_q <= pos_q - PosW'(1);
          end
        end
        // One degree of the remainder per cycle.
        S_RED: begin
          if (pos_q > dpos_q) begin
            pos_q <= pos_q - PosW'(1);
            dsh_q <= dsh_q >> 1;
          end else begin
            st_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (op_q == OP_GCD && r_row != '0) begin
            pos_q <= PosW'(RowW - 1);
            st_q  <= S_ALIGN;
          end else begin
            st_q <= S_DONE;
          end
        end
        default: begin
          done_q <= 1'b1;
          busy_q <= 1'b0;
          zd_q   <= (op_q == OP_DIV) && (d_row == '0);
          rem_q  <= '0;
          main_q <= '0;
          case (op_q)
            OP_MUL: main_q <= MainW'(r_row[RowW-2:0]);
            OP_DIV: if (d_row != '0) begin
              main_q <= MainW'(q_row);
              rem_q  <= 32'(r_row[WIDTH-1:0]);
            end
            OP_GCD: main_q <= (d_row == '0) ? MainW'(r_row[WIDTH-1:0])
                                            : MainW'(d_row[WIDTH-1:0]);
            default: main_q <= '0;
          endcase
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = busy_q;
  assign done_o            = done_q;
  assign main_value_o      = main_q;
  assign remainder_value_o = rem_q;
  assign zero_divisor_o    = zd_q;
endmodule

/* rtl/gpa_checker.sv */
// Port-level checks on the arithmetic unit.
module gpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [62:0] main_value_o,
  input logic [31:0] remainder_value_o,
  input logic        zero_divisor_o
);
  // An accepted transaction makes the unit busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");
  // A result ends the busy period.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy during result");
  // A result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  // A zero divisor result carries zero values.
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_divisor_o |-> main_value_o == '0 && remainder_value_o == '0)
    else $error("zero divisor result not cleared");
endmodule

bind gf2_polynomial_alu_core gpa_checker u_gpa_checker (.*);

/* bench/gpa_checker.sv */
module gpa_scoreboard (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [1:0]                opcode_i,
  input  logic [31:0]               operand_a_i,
  input  logic [31:0]               operand_b_i,
  input  logic                      done_i,
  input  logic [gpa_pkg::MainW-1:0] main_value_i,
  input  logic [31:0]               remainder_value_i,
  input  logic                      zero_divisor_i,
  output int                        mismatch_count_o,
  output int                        awaited_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gpa_pkg::*;

  typedef struct packed {
    logic [MainW-1:0] main_value;
    logic [31:0]      remainder_value;
    logic             zero_divisor;
  } alu_answer_t;

  alu_answer_t awaited_answers[$];

  // Position of the highest set coefficient; the polynomial must be nonzero.
  function automatic int poly_degree(input logic [31:0] poly);
    int deg;
    deg = 0;
    for (int i = 0; i < 32; i++) begin
      if (poly[i]) deg = i;
    end
    return deg;
  endfunction

  function automatic logic [MainW-1:0] carryless_product(input logic [31:0] a,
                                                         input logic [31:0] b);
    logic [MainW-1:0] acc;
    acc = '0;
    for (int i = 0; i < 32; i++) begin
      if (a[i]) acc ^= {31'b0, b} << i;
    end
    return acc;
  endfunction

  // Long division; the divisor must be nonzero.
  function automatic void poly_long_divide(input logic [31:0] num, input logic [31:0] den,
                                           output logic [31:0] quo,
                                           output logic [31:0] rem);
    int den_deg;
    den_deg = poly_degree(den);
    quo = '0;
    rem = num;
    for (int i = 31; i >= den_deg; i--) begin
      if (rem[i]) begin
        rem ^= den << (i - den_deg);
        quo[i - den_deg] = 1'b1;
      end
    end
  endfunction

  function automatic logic [31:0] poly_euclid_gcd(input logic [31:0] a,
                                                  input logic [31:0] b);
    logic [31:0] quo;
    logic [31:0] rem;
    for (int guard = 0; guard < 66 && b != '0; guard++) begin
      poly_long_divide(a, b, quo, rem);
      a = b;
      b = rem;
    end
    return a;
  endfunction

  function automatic alu_answer_t compute_answer(input op_e op, input logic [31:0] a,
                                                 input logic [31:0] b);
    alu_answer_t ans;
    logic [31:0] quo;
    logic [31:0] rem;
    ans = '0;
    case (op)
      OP_MUL: begin
        ans.main_value = carryless_product(a, b);
      end
      OP_DIV: begin
        if (b == '0) begin
          ans.zero_divisor = 1'b1;
        end else begin
          poly_long_divide(a, b, quo, rem);
          ans.main_value      = {31'b0, quo};
          ans.remainder_value = rem;
        end
      end
      OP_GCD: begin
        ans.main_value = {31'b0, poly_euclid_gcd(a, b)};
      end
      default: begin
        ans = '0;
      end
    endcase
    return ans;
  endfunction

  // Predict on each accepted transaction and compare each strobed result.
  always @(posedge clk_i or negedge rst_ni) begin
    alu_answer_t exp_ans;
    int          errs;
    if (!rst_ni) begin
      awaited_answers.delete();
      mismatch_count_o <= 0;
      awaited_count_o  <= 0;
    end else begin
      errs = 0;
      if (start_i && !busy_i) begin
        awaited_answers = {awaited_answers,
                           compute_answer(op_e'(opcode_i), operand_a_i, operand_b_i)};
      end
      if (done_i) begin
        if (awaited_answers.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          errs++;
        end else begin
          exp_ans = awaited_answers.pop_front();
          if (main_value_i !== exp_ans.main_value) begin
            $error("main_value: expected %h, got %h", exp_ans.main_value, main_value_i);
            errs++;
          end
          if (remainder_value_i !== exp_ans.remainder_value) begin
            $error("remainder_value: expected %h, got %h", exp_ans.remainder_value,
                   remainder_value_i);
            errs++;
          end
          if (zero_divisor_i !== exp_ans.zero_divisor) begin
            $error("zero_divisor: expected %b, got %b", exp_ans.zero_divisor,
                   zero_divisor_i);
            errs++;
          end
        end
      end
      mismatch_count_o <= mismatch_count_o + errs;
      awaited_count_o  <= awaited_answers.size();
    end
  end

endmodule

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gpa_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          opcode_i;
  logic [31:0]         operand_a_i;
  logic [31:0]         operand_b_i;
  logic                done_o;
  logic [MainW-1:0]    main_value_o;
  logic [31:0]         remainder_value_o;
  logic                zero_divisor_o;
  int                  mismatch_count;
  int                  awaited_count;
  int                  sent_per_op[4];

  gf2_polynomial_alu_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .opcode_i(opcode_i), .operand_a_i(operand_a_i), .operand_b_i(operand_b_i),
    .done_o(done_o), .main_value_o(main_value_o),
    .remainder_value_o(remainder_value_o), .zero_divisor_o(zero_divisor_o)
  );

  gpa_scoreboard u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .opcode_i(opcode_i), .operand_a_i(operand_a_i), .operand_b_i(operand_b_i),
    .done_i(done_o), .main_value_i(main_value_o),
    .remainder_value_i(remainder_value_o), .zero_divisor_i(zero_divisor_o),
    .mismatch_count_o(mismatch_count), .awaited_count_o(awaited_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hand one transaction to the block; start drops at the next falling edge.
  task automatic issue_op(input op_e op, input logic [31:0] a, input logic [31:0] b);
    while (busy) @(negedge clk_i);
    start       = 1'b1;
    opcode_i    = op;
    operand_a_i = a;
    operand_b_i = b;
    sent_per_op[op]++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Operand with a random degree so that short polynomials are common.
  function automatic logic [31:0] shaped_operand();
    logic [31:0] val;
    val = $urandom();
    case ($urandom_range(0, 5))
      0:       val = val >> $urandom_range(0, 31);
      1:       val = val & $urandom() & $urandom();
      2:       val = 32'd1 << $urandom_range(0, 31);
      3:       val = (val >> $urandom_range(16, 31)) | 32'h8000_0000;
      default: val = val;
    endcase
    return val;
  endfunction

  function automatic op_e random_op();
    case ($urandom_range(0, 15))
      0:       return OP_NOP;
      1, 2, 3, 4, 5:    return OP_MUL;
      6, 7, 8, 9, 10:   return OP_DIV;
      default: return OP_GCD;
    endcase
  endfunction

  // Carry-less product of a short factor with polynomial b (the callers pass degree-7 0xB7).
  function automatic logic [31:0] u_mul16(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < 16; i++) begin
      if (a[i]) acc ^= b << i;
    end
    return acc;
  endfunction

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    op_e         op;
    start       = 1'b0;
    opcode_i    = OP_NOP;
    operand_a_i = '0;
    operand_b_i = '0;
    rst_ni      = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corners: field extremes, zero divisor, low-degree dividend, gcd with zero.
    issue_op(OP_MUL, 32'h0, 32'h0);
    issue_op(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    issue_op(OP_MUL, 32'h1, 32'hDEAD_BEEF);
    issue_op(OP_DIV, 32'hFFFF_FFFF, 32'h0);
    issue_op(OP_DIV, 32'h0, 32'h0);
    issue_op(OP_DIV, 32'h0, 32'h13);
    issue_op(OP_DIV, 32'h5, 32'h8000_0000);
    issue_op(OP_DIV, 32'hFFFF_FFFF, 32'h1);
    issue_op(OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_op(OP_DIV, 32'h8000_0000, 32'h3);
    issue_op(OP_GCD, 32'h1234_5678, 32'h0);
    issue_op(OP_GCD, 32'h0, 32'h8765_4321);
    issue_op(OP_GCD, 32'h0, 32'h0);
    issue_op(OP_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_op(OP_GCD, 32'h8000_0000, 32'h7FFF_FFFF);
    issue_op(OP_GCD, 32'h3, 32'h8000_0001);
    issue_op(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_op(OP_NOP, 32'h0, 32'h0);

    // Let the queue drain completely before random traffic.
    while (awaited_count != 0) @(negedge clk_i);

    // Random traffic with idle bursts; the final stretch runs back to back.
    for (int n = 0; n < 1330; n++) begin
      if (n < 1100 && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 19)) @(negedge clk_i);
      if (n == 600) while (awaited_count != 0) @(negedge clk_i);
      op = random_op();
      a  = shaped_operand();
      b  = ($urandom_range(0, 19) == 0) ? 32'h0 : shaped_operand();
      // Some gcd pairs share a factor so the result is nontrivial.
      if (op == OP_GCD && $urandom_range(0, 2) == 0) begin
        a = (a & 32'hFFFF) << 0;
        b = b & 32'hFFFF;
        a = 32'(u_mul16(a, 32'h0000_00B7));
        b = 32'(u_mul16(b, 32'h0000_00B7));
      end
      issue_op(op, a, b);
    end

    while (awaited_count != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);

    $display("Covered %0d multiplies, %0d divides, %0d gcds, %0d unused-opcode transactions,",
             sent_per_op[OP_MUL], sent_per_op[OP_DIV], sent_per_op[OP_GCD],
             sent_per_op[OP_NOP]);
    $display("including zero divisors, low-degree dividends and gcds with zero operands.");
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("gf2_polynomial_alu_core verification clean");
    end else begin
      $display("gf2_polynomial_alu_core verification failed");
    end
    $finish;
  end

  initial begin
    #250ms;
    $display("gf2_polynomial_alu_core verification failed");
    $finish;
  end

endmodule
